### rtl/core/btx_pkg.sv
// Shared constants and controller/datapath interface types for the bilinear sampler.
// Used by btx_ctrl, btx_dp and the top level in rtl/core; no dependencies of its own.
`timescale 1ns / 1ps

package btx_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // Fixed field widths.
  localparam int COORD_FRAC = 16;             // fraction bits of u and v
  localparam int CIW        = 18;             // signed coordinate port width
  localparam int CW         = COORD_FRAC + 1; // clamped coordinate, 0 to 1.0
  localparam int SZW        = 9;              // size register width
  localparam int PIXW       = 24;             // stored RGB pixel

  // Command codes of an input item.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [SZW-1:0] SIZE_RESET = SZW'(256);

  // Texel of the 2x2 neighborhood.
  localparam logic [1:0] TEX_00 = 2'd0;
  localparam logic [1:0] TEX_10 = 2'd1;
  localparam logic [1:0] TEX_01 = 2'd2;
  localparam logic [1:0] TEX_11 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;     // latch an accepted item
    logic       mul;      // scale u,v by the image size
    logic [1:0] tex_sel;  // texel address driven to the pixel memory
    logic       cap_en;   // capture the texel read in the previous cycle
    logic [1:0] cap_sel;
    logic       hblend;   // horizontal blend of all channels
    logic       smp_emit; // load a sample result into the output register
    logic       wr_emit;  // store the pixel and load a write result
  } btx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;       // output register can take a result this cycle
  } btx_stat_t;

endpackage

### rtl/core/btx_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; contents are undefined after reset.
`timescale 1ns / 1ps

module btx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One read per cycle, plus a write when we_i is set, at a shared address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/btx_ctrl.sv
// Controller state machine of the bilinear sampler.
// Depends on btx_pkg for the command and status types.
`timescale 1ns / 1ps

module btx_ctrl
  import btx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      cmd_i,
  input  btx_stat_t stat_i,
  output btx_cmd_t  ctl_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_RD0    = 4'd2;
  localparam logic [3:0] S_RD1    = 4'd3;
  localparam logic [3:0] S_RD2    = 4'd4;
  localparam logic [3:0] S_RD3    = 4'd5;
  localparam logic [3:0] S_HBLEND = 4'd6;
  localparam logic [3:0] S_VBLEND = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;

  logic [3:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = (cmd_i == CMD_SAMPLE) ? S_MUL : S_WR;
        end
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d   = S_RD0;
      end
      S_RD0: begin
        ctl_o.tex_sel = TEX_00;
        state_d       = S_RD1;
      end
      S_RD1: begin
        ctl_o.tex_sel = TEX_10;
        ctl_o.cap_en  = 1'b1;
        ctl_o.cap_sel = TEX_00;
        state_d       = S_RD2;
      end
      S_RD2: begin
        ctl_o.tex_sel = TEX_01;
        ctl_o.cap_en  = 1'b1;
        ctl_o.cap_sel = TEX_10;
        state_d       = S_RD3;
      end
      S_RD3: begin
        ctl_o.tex_sel = TEX_11;
        ctl_o.cap_en  = 1'b1;
        ctl_o.cap_sel = TEX_01;
        state_d       = S_HBLEND;
      end
      S_HBLEND: begin
        // The last texel is used straight from the memory read port.
        ctl_o.hblend = 1'b1;
        state_d      = S_VBLEND;
      end
      S_VBLEND: begin
        if (stat_i.out_free) begin
          ctl_o.smp_emit = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_WR: begin
        if (stat_i.out_free) begin
          ctl_o.wr_emit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/btx_dp.sv
// Datapath of the bilinear sampler: size registers, coordinate scaling,
// texel addressing, blending and the output register. Uses btx_pkg and btx_ram.
`timescale 1ns / 1ps

module btx_dp
  import btx_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btx_cmd_t              ctl_i,
  output btx_stat_t             stat_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [SZW-1:0]        cfg_data_i,
  input  logic [7:0]            pixel_x_i,
  input  logic [7:0]            pixel_y_i,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  input  logic signed [CIW-1:0] u_coord_i,
  input  logic signed [CIW-1:0] v_coord_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic                  coord_error_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = CW + SZW;          // scaled position
  localparam int IW    = PW - COORD_FRAC;   // integer texel index
  localparam int WW    = FRAC_BITS + 1;     // weight including 1.0
  localparam int HW    = FRAC_BITS + 8;     // horizontal blend
  localparam int VW    = 2 * FRAC_BITS + 8; // vertical blend
  localparam logic [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;

  // Clamp a signed Q2.16 coordinate to the range 0 to 1.0.
  function automatic logic [CW-1:0] clamp_coord(input logic signed [CIW-1:0] c);
    logic [CW-1:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c > $signed(CIW'(1 << COORD_FRAC))) begin
      r = CW'(1 << COORD_FRAC);
    end else begin
      r = c[CW-1:0];
    end
    return r;
  endfunction

  // Two-tap blend of one channel along x.
  function automatic logic [HW-1:0] hmix(input logic [WW-1:0] nw,
                                         input logic [FRAC_BITS-1:0] w,
                                         input logic [7:0] a,
                                         input logic [7:0] b);
    logic [HW+1:0] s;
    s = (HW+2)'(nw) * (HW+2)'(a) + (HW+2)'(w) * (HW+2)'(b);
    return s[HW-1:0];
  endfunction

  // Two-tap blend of the row results along y, truncated to 8 bits.
  function automatic logic [7:0] vmix(input logic [WW-1:0] nw,
                                      input logic [FRAC_BITS-1:0] w,
                                      input logic [HW-1:0] a,
                                      input logic [HW-1:0] b);
    logic [VW+1:0] s;
    s = (VW+2)'(nw) * (VW+2)'(a) + (VW+2)'(w) * (VW+2)'(b);
    return s[VW-1 -: 8];
  endfunction

  // Row-major address with a fixed row stride.
  function automatic logic [AW-1:0] tex_addr(input logic [IW-1:0] x,
                                             input logic [IW-1:0] y);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  logic [SZW-1:0]  width_q, height_q;
  logic [SZW-1:0]  w_eff, h_eff, wm1, hm1;
  logic [7:0]      x_q, y_q;
  logic [PIXW-1:0] pix_q;
  logic [CW-1:0]   u_q, v_q;
  logic [PW-1:0]   px_q, py_q;
  logic [IW-1:0]   x0, y0, x1, y1, ax, ay;
  logic [IW:0]     x0p1, y0p1;
  logic [FRAC_BITS-1:0] dx, dy;
  logic [WW-1:0]   ndx, ndy;
  logic [PIXW-1:0] c00_q, c10_q, c01_q;
  logic [PIXW-1:0] rdata;
  logic [HW-1:0]   top_q [3];
  logic [HW-1:0]   bot_q [3];
  logic            in_range;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic            out_valid_q;
  logic [PIXW-1:0] out_rgb_q;
  logic            err_q;

  // Size registers, to be written by the user only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_idx_i == REG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Sizes in use: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (width_q == '0) begin
      w_eff = SZW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = SZW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = SZW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = SZW'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    wm1 = w_eff - SZW'(1);
    hm1 = h_eff - SZW'(1);
  end

  // Item registers and the scaled sample position.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q   <= pixel_x_i;
      y_q   <= pixel_y_i;
      pix_q <= {in_red_i, in_green_i, in_blue_i};
      u_q   <= clamp_coord(u_coord_i);
      v_q   <= clamp_coord(v_coord_i);
    end
    if (ctl_i.mul) begin
      px_q <= PW'(u_q) * PW'(wm1);
      py_q <= PW'(v_q) * PW'(hm1);
    end
  end

  // Neighbor indexes; the far neighbor is held at the image edge.
  assign x0   = px_q[PW-1:COORD_FRAC];
  assign y0   = py_q[PW-1:COORD_FRAC];
  assign x0p1 = {1'b0, x0} + (IW+1)'(1);
  assign y0p1 = {1'b0, y0} + (IW+1)'(1);
  assign x1   = (x0p1 < (IW+1)'(w_eff)) ? x0p1[IW-1:0] : IW'(wm1);
  assign y1   = (y0p1 < (IW+1)'(h_eff)) ? y0p1[IW-1:0] : IW'(hm1);

  // Fractions taken to the weight precision.
  if (FRAC_BITS >= COORD_FRAC) begin : g_wt_up
    assign dx = FRAC_BITS'(px_q[COORD_FRAC-1:0]) << (FRAC_BITS - COORD_FRAC);
    assign dy = FRAC_BITS'(py_q[COORD_FRAC-1:0]) << (FRAC_BITS - COORD_FRAC);
  end else begin : g_wt_dn
    assign dx = FRAC_BITS'(px_q[COORD_FRAC-1:0] >> (COORD_FRAC - FRAC_BITS));
    assign dy = FRAC_BITS'(py_q[COORD_FRAC-1:0] >> (COORD_FRAC - FRAC_BITS));
  end
  assign ndx = ONE_W - WW'(dx);
  assign ndy = ONE_W - WW'(dy);

  // Texel address for the current read.
  always_comb begin
    case (ctl_i.tex_sel)
      TEX_00: begin
        ax = x0;
        ay = y0;
      end
      TEX_10: begin
        ax = x1;
        ay = y0;
      end
      TEX_01: begin
        ax = x0;
        ay = y1;
      end
      TEX_11: begin
        ax = x1;
        ay = y1;
      end
      default: begin
        ax = x0;
        ay = y0;
      end
    endcase
  end

  // Pixel writes share the single memory port with texel reads.
  assign in_range = ({1'b0, x_q} < w_eff) && ({1'b0, y_q} < h_eff);
  assign ram_we   = ctl_i.wr_emit && in_range;
  assign ram_addr = ctl_i.wr_emit ? tex_addr(IW'(x_q), IW'(y_q)) : tex_addr(ax, ay);

  btx_ram #(
    .WIDTH(PIXW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(pix_q),
    .rdata_o(rdata)
  );

  // Texel capture and the horizontal blend of all three channels.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_en) begin
      case (ctl_i.cap_sel)
        TEX_00:  c00_q <= rdata;
        TEX_10:  c10_q <= rdata;
        TEX_01:  c01_q <= rdata;
        default: c00_q <= c00_q;
      endcase
    end
    if (ctl_i.hblend) begin
      for (int k = 0; k < 3; k++) begin
        top_q[k] <= hmix(ndx, dx, c00_q[PIXW-1-8*k -: 8], c10_q[PIXW-1-8*k -: 8]);
        bot_q[k] <= hmix(ndx, dx, c01_q[PIXW-1-8*k -: 8], rdata[PIXW-1-8*k -: 8]);
      end
    end
  end

  // Output register: a result waits here while the next item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.smp_emit || ctl_i.wr_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.smp_emit) begin
      out_rgb_q <= {vmix(ndy, dy, top_q[0], bot_q[0]),
                    vmix(ndy, dy, top_q[1], bot_q[1]),
                    vmix(ndy, dy, top_q[2], bot_q[2])};
      err_q     <= 1'b0;
    end else if (ctl_i.wr_emit) begin
      out_rgb_q <= '0;
      err_q     <= !in_range;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_rgb_q[23:16];
  assign out_green_o     = out_rgb_q[15:8];
  assign out_blue_o      = out_rgb_q[7:0];
  assign coord_error_o   = err_q;

endmodule

### rtl/core/bilinear_texture_sampler.sv
// Bilinear texture sampler. A sample is scaled, reads its four texels one after
// another through the single-port pixel memory and takes two blend steps; a pixel
// write is stored directly. Each item waits until the output register is free to
// load its result, and the next item is accepted only after that load.
// Reset clears the controller and output valid and sets both sizes to 256; the
// pixel memory is not cleared and holds nothing defined until written.
`timescale 1ns / 1ps

module bilinear_texture_sampler
  import btx_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [SZW-1:0]        cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [7:0]            pixel_x_i,
  input  logic [7:0]            pixel_y_i,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  input  logic signed [CIW-1:0] u_coord_i,
  input  logic signed [CIW-1:0] v_coord_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic                  coord_error_o
);

  btx_cmd_t  ctl;
  btx_stat_t stat;

  btx_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i     (cmd_i),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  btx_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .coord_error_o(coord_error_o)
  );

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.smp_emit || ctl.wr_emit) |-> stat.out_free)
    else $error("result loaded over a pending output");

  // One item at a time: no transfer in the cycle after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // Write and sample results never load together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.smp_emit && ctl.wr_emit))
    else $error("write and sample results loaded together");

  // A coordinate error carries zero color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && coord_error_o) |->
      (out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0))
    else $error("coordinate error with nonzero color");

endmodule

### bench/tb.sv
// Self-checking testbench for bilinear_texture_sampler: pixel writes, bilinear samples, size registers.
// Depends on btx_pkg and the sampler RTL only. It predicts every result and compares it field by field.
`timescale 1ns / 1ps

module tb;
  import btx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned STORE_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  // One input item as the sender presents it.
  typedef struct packed {
    logic                  cmd;
    logic [7:0]            x;
    logic [7:0]            y;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic signed [CIW-1:0] u;
    logic signed [CIW-1:0] v;
  } texel_req_t;

  // One result item.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } pixel_result_t;

  // Texel neighborhood and blend weights of one sample.
  typedef struct {
    int unsigned       x0;
    int unsigned       x1;
    int unsigned       y0;
    int unsigned       y1;
    longint unsigned   wx;
    longint unsigned   wy;
  } quad_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [SZW-1:0]        cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  cmd_i;
  logic [7:0]            pixel_x_i;
  logic [7:0]            pixel_y_i;
  logic [7:0]            in_red_i;
  logic [7:0]            in_green_i;
  logic [7:0]            in_blue_i;
  logic signed [CIW-1:0] u_coord_i;
  logic signed [CIW-1:0] v_coord_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            out_red_o;
  logic [7:0]            out_green_o;
  logic [7:0]            out_blue_o;
  logic                  coord_error_o;

  bilinear_texture_sampler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .coord_error_o(coord_error_o)
  );

  // Shadow copy of the image, the size registers and the results still owed.
  logic [PIXW-1:0] image_mem   [STORE_WORDS];
  bit              written_map [STORE_WORDS];
  logic [SZW-1:0]  width_reg  = SIZE_RESET;
  logic [SZW-1:0]  height_reg = SIZE_RESET;
  pixel_result_t   expected_pixels [$];
  pixel_result_t   oldest_pixel;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned sent_count     = 0;
  int unsigned send_idle_pct  = 24;
  int unsigned recv_idle_pct  = 55;
  int unsigned recv_hold_req  = 0;

  // A size register of zero acts as one, and one above the maximum acts as the maximum.
  function automatic int unsigned eff_dim(logic [SZW-1:0] r, int unsigned maxv);
    if (r == '0) return 1;
    if (r > maxv) return maxv;
    return r;
  endfunction

  // Clamp a signed Q2.16 coordinate to the range 0.0 to 1.0.
  function automatic int unsigned clamp_uv(logic signed [CIW-1:0] c);
    if (c < 0) return 0;
    if (c > $signed(CIW'(1 << COORD_FRAC))) return 1 << COORD_FRAC;
    return int'(c);
  endfunction

  // Scale u,v by the image size and find the 2x2 neighborhood and its weights.
  function automatic quad_t locate_quad(logic signed [CIW-1:0] u, logic signed [CIW-1:0] v);
    quad_t       q;
    int unsigned w;
    int unsigned h;
    int unsigned px;
    int unsigned py;
    w    = eff_dim(width_reg, DEF_MAX_WIDTH);
    h    = eff_dim(height_reg, DEF_MAX_HEIGHT);
    px   = clamp_uv(u) * (w - 1);
    py   = clamp_uv(v) * (h - 1);
    q.x0 = px >> COORD_FRAC;
    q.y0 = py >> COORD_FRAC;
    q.x1 = (q.x0 + 1 < w) ? q.x0 + 1 : w - 1;
    q.y1 = (q.y0 + 1 < h) ? q.y0 + 1 : h - 1;
    px   = px & ((1 << COORD_FRAC) - 1);
    py   = py & ((1 << COORD_FRAC) - 1);
    if (DEF_FRAC_BITS >= COORD_FRAC) begin
      q.wx = longint'(px) << (DEF_FRAC_BITS - COORD_FRAC);
      q.wy = longint'(py) << (DEF_FRAC_BITS - COORD_FRAC);
    end else begin
      q.wx = px >> (COORD_FRAC - DEF_FRAC_BITS);
      q.wy = py >> (COORD_FRAC - DEF_FRAC_BITS);
    end
    return q;
  endfunction

  // Horizontal then vertical blend of one channel, truncated to 8 bits.
  function automatic logic [7:0] blend_channel(logic [7:0] a00, logic [7:0] a10,
                                               logic [7:0] a01, logic [7:0] a11,
                                               longint unsigned wx, longint unsigned wy);
    longint unsigned one;
    longint unsigned top;
    longint unsigned bot;
    longint unsigned sum;
    one = 64'd1 << DEF_FRAC_BITS;
    top = (one - wx) * a00 + wx * a10;
    bot = (one - wx) * a01 + wx * a11;
    sum = (one - wy) * top + wy * bot;
    return 8'(sum >> (2 * DEF_FRAC_BITS));
  endfunction

  // Apply one accepted item to the shadow image and return the result it owes.
  function automatic pixel_result_t sampler_outcome(texel_req_t t);
    pixel_result_t   res;
    quad_t           q;
    int unsigned     addr;
    logic [PIXW-1:0] c00;
    logic [PIXW-1:0] c10;
    logic [PIXW-1:0] c01;
    logic [PIXW-1:0] c11;
    res = '0;
    if (t.cmd == CMD_WRITE) begin
      if (t.x >= eff_dim(width_reg, DEF_MAX_WIDTH) ||
          t.y >= eff_dim(height_reg, DEF_MAX_HEIGHT)) begin
        res.err = 1'b1;
      end else begin
        addr              = t.y * DEF_MAX_WIDTH + t.x;
        image_mem[addr]   = {t.red, t.green, t.blue};
        written_map[addr] = 1'b1;
      end
    end else begin
      q         = locate_quad(t.u, t.v);
      c00       = image_mem[q.y0 * DEF_MAX_WIDTH + q.x0];
      c10       = image_mem[q.y0 * DEF_MAX_WIDTH + q.x1];
      c01       = image_mem[q.y1 * DEF_MAX_WIDTH + q.x0];
      c11       = image_mem[q.y1 * DEF_MAX_WIDTH + q.x1];
      res.red   = blend_channel(c00[23:16], c10[23:16], c01[23:16], c11[23:16], q.wx, q.wy);
      res.green = blend_channel(c00[15:8], c10[15:8], c01[15:8], c11[15:8], q.wx, q.wy);
      res.blue  = blend_channel(c00[7:0], c10[7:0], c01[7:0], c11[7:0], q.wx, q.wy);
    end
    return res;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a run that has not ended by the limit has hung.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // Output ready: random stalls, or a long hold-off when a test asks for one.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold_req != 0) begin
        hold_left     = recv_hold_req;
        recv_hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rgb %0d %0d %0d err %0d",
                 $time, out_red_o, out_green_o, out_blue_o, coord_error_o);
        mismatch_count++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        compare_field("out_red", oldest_pixel.red, out_red_o);
        compare_field("out_green", oldest_pixel.green, out_green_o);
        compare_field("out_blue", oldest_pixel.blue, out_blue_o);
        compare_field("coord_error", oldest_pixel.err, coord_error_o);
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer.
  task automatic send_item(input texel_req_t t);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= t.cmd;
    pixel_x_i  <= t.x;
    pixel_y_i  <= t.y;
    in_red_i   <= t.red;
    in_green_i <= t.green;
    in_blue_i  <= t.blue;
    u_coord_i  <= t.u;
    v_coord_i  <= t.v;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(sampler_outcome(t));
    sent_count++;
  endtask

  task automatic put_pixel(input int unsigned x, input int unsigned y,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    texel_req_t t;
    t.cmd   = CMD_WRITE;
    t.x     = x[7:0];
    t.y     = y[7:0];
    t.red   = r;
    t.green = g;
    t.blue  = b;
    t.u     = CIW'($urandom);
    t.v     = CIW'($urandom);
    send_item(t);
  endtask

  // Write any texel of the neighborhood that holds nothing yet, then sample.
  task automatic sample_at(input logic signed [CIW-1:0] u, input logic signed [CIW-1:0] v);
    quad_t       q;
    texel_req_t  t;
    int unsigned cx [4];
    int unsigned cy [4];
    q  = locate_quad(u, v);
    cx = '{q.x0, q.x1, q.x0, q.x1};
    cy = '{q.y0, q.y0, q.y1, q.y1};
    for (int k = 0; k < 4; k++) begin
      if (!written_map[cy[k] * DEF_MAX_WIDTH + cx[k]])
        put_pixel(cx[k], cy[k], 8'($urandom), 8'($urandom), 8'($urandom));
    end
    t.cmd   = CMD_SAMPLE;
    t.x     = 8'($urandom);
    t.y     = 8'($urandom);
    t.red   = 8'($urandom);
    t.green = 8'($urandom);
    t.blue  = 8'($urandom);
    t.u     = u;
    t.v     = v;
    send_item(t);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [SZW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) width_reg = data;
    else height_reg = data;
  endtask

  // Size changes happen only with the block idle.
  task automatic set_size(input logic [SZW-1:0] w, input logic [SZW-1:0] h);
    wait_results_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic logic signed [CIW-1:0] random_coord();
    case ($urandom_range(9))
      0: return CIW'($urandom);
      1: begin
        case ($urandom_range(7))
          0: return -CIW'(131072);
          1: return -CIW'(1);
          2: return CIW'(0);
          3: return CIW'(1);
          4: return CIW'(65535);
          5: return CIW'(65536);
          6: return CIW'(65537);
          default: return CIW'(131071);
        endcase
      end
      default: return CIW'($urandom_range(65536));
    endcase
  endfunction

  // One random item: a write, often inside the image, or a sample.
  task automatic random_item();
    int unsigned w;
    int unsigned h;
    w = eff_dim(width_reg, DEF_MAX_WIDTH);
    h = eff_dim(height_reg, DEF_MAX_HEIGHT);
    if ($urandom_range(99) < 45) begin
      if ($urandom_range(3) == 0)
        put_pixel($urandom_range(255), $urandom_range(255),
                  8'($urandom), 8'($urandom), 8'($urandom));
      else
        put_pixel($urandom_range(w - 1), $urandom_range(h - 1),
                  8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      sample_at(random_coord(), random_coord());
    end
  endtask

  task automatic pick_size();
    case ($urandom_range(7))
      0: set_size(9'd256, 9'd256);
      1: set_size(9'd0, 9'd0);
      2: set_size(9'd511, 9'd511);
      3: set_size(9'd1, 9'd256);
      4: set_size(9'd256, 9'd1);
      5: set_size(9'd2, 9'd2);
      6: set_size(SZW'($urandom_range(1, 16)), SZW'($urandom_range(1, 16)));
      default: set_size(SZW'($urandom_range(511)), SZW'($urandom_range(511)));
    endcase
  endtask

  // Reset sizes of 256x256: corner writes, clamped and edge samples.
  task automatic test_default_size();
    put_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    put_pixel(255, 255, 8'hFF, 8'hFF, 8'hFF);
    put_pixel(255, 0, 8'hA5, 8'h5A, 8'hFF);
    put_pixel(0, 255, 8'h5A, 8'hA5, 8'h00);
    sample_at(-CIW'(131072), -CIW'(131072));
    sample_at(CIW'(131071), CIW'(131071));
    sample_at(CIW'(65536), CIW'(0));
    sample_at(CIW'(32768), CIW'(32768));
  endtask

  // Zero and oversized registers, writes just outside the image, a one-pixel image.
  task automatic test_size_extremes();
    set_size(9'd0, 9'd511);
    put_pixel(1, 0, 8'h11, 8'h22, 8'h33);
    put_pixel(0, 200, 8'h44, 8'h55, 8'h66);
    sample_at(CIW'(65536), CIW'(32768));
    set_size(9'd511, 9'd0);
    put_pixel(0, 1, 8'h77, 8'h88, 8'h99);
    put_pixel(255, 0, 8'hFF, 8'h00, 8'h80);
    sample_at(CIW'(65535), CIW'(65536));
    set_size(9'd1, 9'd1);
    put_pixel(0, 0, 8'hC3, 8'h3C, 8'h81);
    put_pixel(0, 1, 8'h01, 8'h02, 8'h03);
    sample_at(CIW'(131071), -CIW'(1));
    set_size(9'd256, 9'd256);
    put_pixel(255, 255, 8'h12, 8'h34, 8'h56);
  endtask

  // Mixed random traffic until n_items transfers have gone in, with a new
  // image size every hundred random picks.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned start_count;
    start_count = sent_count;
    for (int unsigned i = 0; sent_count - start_count < n_items; i++) begin
      if (i % 100 == 0) pick_size();
      random_item();
    end
  endtask

  // The receiver holds off while the sender keeps offering, then the sender
  // pauses until everything is out.
  task automatic test_output_holdoff();
    recv_hold_req = 200;
    repeat (20) random_item();
    wait_results_drained();
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i      = CMD_WRITE;
    pixel_x_i  = '0;
    pixel_y_i  = '0;
    in_red_i   = '0;
    in_green_i = '0;
    in_blue_i  = '0;
    u_coord_i  = '0;
    v_coord_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 55;
    test_default_size();
    test_size_extremes();
    test_random_traffic(700);

    send_idle_pct = 55;
    recv_idle_pct = 24;
    test_random_traffic(700);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_holdoff();
    test_random_traffic(600);

    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
